// File: hdl/weekly_schedule_value_lookup_top_defines.svh
// assertion macros used by the checker file of the schedule lookup block
// depends on nothing; included by bare file name
`ifndef WEEKLY_SCHEDULE_VALUE_LOOKUP_TOP_DEFINES_SVH
`define WEEKLY_SCHEDULE_VALUE_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WSVL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsvl assertion failed");

// next-cycle implication, disabled while reset is low
`define WSVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsvl assertion failed");

`endif

// File: hdl/wsvl_pkg.sv
// shared types, constants and elaboration-time calendar tables of the schedule lookup
// used by wsvl_ctrl, wsvl_dp and the top level
`default_nettype none

package wsvl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TIME  = 1'b1;

    localparam logic [1:0] CFG_INIT  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    localparam logic [32:0] SECS_PER_WEEK = 33'd604800;
    localparam logic [32:0] SHIFT_3DAYS   = 33'd259200;
    localparam logic signed [33:0] OFF_STD = -34'sd3600;
    localparam logic signed [33:0] OFF_DST = -34'sd7200;
    localparam logic [3:0] DIV_TOP = 4'd1;
    // 2^39 / (604800 >> 7) rounded up, exact quotient for any 26-bit dividend
    localparam logic [26:0] WEEK_RECIP = 27'd116350437;

    // year windows cover every time the walk can reach
    localparam int YEAR0 = 1969;
    localparam int NYEAR = 138;
    localparam int NWIN  = NYEAR + 1;
    localparam int NBKT  = 256;
    localparam int BKT_SH = 25;
    localparam logic signed [33:0] BKT_BIAS = 34'sd33554432;
    localparam longint FAR_TIME = 64'sd8589934591;

    typedef logic signed [33:0] t_time;
    typedef logic [7:0] t_win_idx;
    typedef t_time t_win_arr [NWIN];
    typedef t_win_idx t_bkt_arr [NBKT];

    typedef struct packed {
        logic wr_entry;
        logic start;
        logic div_step;
        logic set_sow;
        logic rd_mem;
        logic set_x;
        logic bucket;
        logic cmp;
        logic app_init;
        logic app_entry;
        logic app_tail;
        logic out_load;
        logic out_rec;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic div_done;
        logic n_zero;
        logic brk;
        logic last;
        logic out_free;
    } t_sts;

    function automatic longint days_from_civil(longint y_in, longint m, longint d);
        longint y;
        longint era;
        longint yoe;
        longint mm;
        longint doy;
        longint doe;
        y = (m <= 2) ? y_in - 1 : y_in;
        era = y / 400;
        yoe = y - era * 400;
        mm = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mm + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic longint last_sunday(longint y, longint m);
        longint last;
        longint wd;
        last = days_from_civil(y, m, 31);
        wd = (((last + 3) % 7) + 7) % 7;
        return last - ((wd + 1) % 7);
    endfunction

    // summer time starts last sunday of march 02:00 local
    function automatic t_win_arr build_beg();
        t_win_arr a;
        for (int i = 0; i < NWIN; i++) begin
            if (i < NYEAR) begin
                a[i] = t_time'(last_sunday(YEAR0 + i, 3) * 86400 + 7200);
            end else begin
                a[i] = t_time'(FAR_TIME);
            end
        end
        return a;
    endfunction

    // and ends last sunday of october 03:00 local
    function automatic t_win_arr build_end();
        t_win_arr a;
        for (int i = 0; i < NWIN; i++) begin
            if (i < NYEAR) begin
                a[i] = t_time'(last_sunday(YEAR0 + i, 10) * 86400 + 10800);
            end else begin
                a[i] = t_time'(FAR_TIME);
            end
        end
        return a;
    endfunction

    // first window that ends after the bucket start; it and the next cover the bucket
    function automatic t_bkt_arr build_bkt();
        t_bkt_arr a;
        t_win_arr e;
        longint bstart;
        int k;
        e = build_end();
        for (int b = 0; b < NBKT; b++) begin
            bstart = longint'(b) * (64'sd1 << BKT_SH) - (64'sd1 << BKT_SH);
            k = 0;
            while (k < NWIN - 2 && longint'(e[k]) <= bstart) begin
                k = k + 1;
            end
            a[b] = t_win_idx'(k);
        end
        return a;
    endfunction

    localparam t_win_arr WIN_BEG = build_beg();
    localparam t_win_arr WIN_END = build_end();
    localparam t_bkt_arr BKT_TBL = build_bkt();

endpackage

`default_nettype wire

// File: hdl/wsvl_ctrl.sv
// controller of the schedule lookup: sequences the week-start divide and the entry walk
// depends on wsvl_pkg
`default_nettype none

module wsvl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    input  wire logic           i_op,
    output logic                o_s_tready,
    input  wire wsvl_pkg::t_sts i_sts,
    output wsvl_pkg::t_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_SOW   = 9'b000000100,
        S_LOAD  = 9'b000001000,
        S_SETX  = 9'b000010000,
        S_BKT   = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_APPLY = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        PH_INIT  = 3'b001,
        PH_ENTRY = 3'b010,
        PH_TAIL  = 3'b100
    } t_phase;

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    logic   r_rec, n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_INIT;
            r_rec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_rec   <= n_rec;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_rec   = r_rec;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_op == wsvl_pkg::OP_TIME && i_sts.due) begin
                        o_cmd.start = 1'b1;
                        n_rec       = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        o_cmd.wr_entry = (i_op == wsvl_pkg::OP_WRITE);
                        n_rec          = 1'b0;
                        n_state        = S_FIN;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_SOW;
                end
            end
            S_SOW: begin
                o_cmd.set_sow = 1'b1;
                if (i_sts.n_zero) begin
                    n_ph    = PH_INIT;
                    n_state = S_BKT;
                end else begin
                    n_ph    = PH_ENTRY;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.rd_mem = 1'b1;
                n_state      = S_SETX;
            end
            S_SETX: begin
                o_cmd.set_x = 1'b1;
                n_state     = S_BKT;
            end
            S_BKT: begin
                o_cmd.bucket = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                case (r_ph)
                    PH_INIT: begin
                        o_cmd.app_init = 1'b1;
                        n_ph           = PH_TAIL;
                        n_state        = S_BKT;
                    end
                    PH_ENTRY: begin
                        o_cmd.app_entry = 1'b1;
                        if (i_sts.brk) begin
                            n_state = S_FIN;
                        end else if (i_sts.last) begin
                            n_ph    = PH_TAIL;
                            n_state = S_BKT;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                    PH_TAIL: begin
                        o_cmd.app_tail = 1'b1;
                        n_state        = S_FIN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_rec  = r_rec;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/wsvl_dp.sv
// datapath of the schedule lookup: entry memory, week-start divider, offset lookup, output
// depends on wsvl_pkg
`default_nettype none

module wsvl_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wsvl_pkg::t_cmd i_cmd,
    output wsvl_pkg::t_sts      o_sts,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic [31:0]    i_time,
    input  wire logic [3:0]     i_idx,
    input  wire logic [19:0]    i_start,
    input  wire logic [31:0]    i_value,
    input  wire logic           i_m_tready,
    output logic                o_m_tvalid,
    output logic [71:0]         o_m_tdata,
    output logic                o_m_tuser
);

    logic [19:0] mem_start [wsvl_pkg::MAX_ENTRIES];
    logic [31:0] mem_value [wsvl_pkg::MAX_ENTRIES];

    logic [31:0] r_init;
    logic [4:0]  r_cnt;
    logic [31:0] r_val;
    logic [32:0] r_vt;
    logic [31:0] r_now;
    logic [32:0] r_rem;
    logic [3:0]  r_div;
    logic [12:0] r_q;
    logic signed [33:0] r_sow;
    logic signed [33:0] r_x;
    logic [4:0]  r_k;
    logic [19:0] r_rs;
    logic [31:0] r_rv;
    logic [31:0] r_cur;
    logic [7:0]  r_bk;
    logic        r_dst;
    logic        r_ov;
    logic [64:0] r_od;
    logic        r_ou;

    logic [4:0]  w_n;
    logic [52:0] w_prod;
    logic [32:0] w_qw;
    logic signed [33:0] w_off;
    logic signed [33:0] w_t;
    logic signed [33:0] w_tail;
    logic signed [33:0] w_u;
    logic [7:0]  w_k1;
    logic        w_in0;
    logic        w_in1;

    assign w_n    = (r_cnt > 5'(wsvl_pkg::MAX_ENTRIES)) ? 5'(wsvl_pkg::MAX_ENTRIES) : r_cnt;
    // 26 by 27 bit product, week count in bits 51:39
    assign w_prod = {27'd0, r_rem[32:7]} * {26'd0, wsvl_pkg::WEEK_RECIP};
    assign w_qw   = {20'd0, r_q} * wsvl_pkg::SECS_PER_WEEK;
    assign w_off  = r_dst ? wsvl_pkg::OFF_DST : wsvl_pkg::OFF_STD;
    assign w_t    = r_x + w_off;
    assign w_tail = r_sow + $signed({1'b0, wsvl_pkg::SECS_PER_WEEK}) + w_off;
    assign w_u    = r_x + wsvl_pkg::BKT_BIAS;
    assign w_k1   = r_bk + 8'd1;
    assign w_in0  = (r_x >= wsvl_pkg::WIN_BEG[r_bk]) && (r_x < wsvl_pkg::WIN_END[r_bk]);
    assign w_in1  = (r_x >= wsvl_pkg::WIN_BEG[w_k1]) && (r_x < wsvl_pkg::WIN_END[w_k1]);

    assign o_sts.due      = ({1'b0, i_time} >= r_vt);
    assign o_sts.div_done = (r_div == 4'd0);
    assign o_sts.n_zero   = (w_n == 5'd0);
    assign o_sts.brk      = (w_t > $signed({2'b00, r_now}));
    assign o_sts.last     = ((r_k + 5'd1) >= w_n);
    assign o_sts.out_free = !r_ov || i_m_tready;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            mem_start[i_idx] <= i_start;
            mem_value[i_idx] <= i_value;
        end
        if (i_cmd.rd_mem) begin
            r_rs <= mem_start[r_k[3:0]];
            r_rv <= mem_value[r_k[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wsvl_pkg::CFG_INIT:  r_init <= i_cfg_data;
                wsvl_pkg::CFG_COUNT: r_cnt  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // scheduled value and valid-until
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_vt  <= '0;
        end else if (i_cmd.app_entry && o_sts.brk) begin
            r_val <= r_cur;
            r_vt  <= w_t[32:0];
        end else if (i_cmd.app_tail) begin
            r_val <= r_cur;
            r_vt  <= w_tail[32:0];
        end
    end

    // walk working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now <= i_time;
            r_rem <= {1'b0, i_time} + wsvl_pkg::SHIFT_3DAYS;
            r_div <= wsvl_pkg::DIV_TOP;
            r_cur <= r_init;
            r_k   <= '0;
        end
        // remainder by one week: reciprocal multiply for the quotient, then subtract
        if (i_cmd.div_step) begin
            if (r_div != 4'd0) begin
                r_q   <= w_prod[51:39];
                r_div <= r_div - 4'd1;
            end else begin
                r_rem <= r_rem - w_qw;
            end
        end
        if (i_cmd.set_sow) begin
            r_sow <= $signed({2'b00, r_now}) - $signed({1'b0, r_rem});
            r_x   <= $signed({2'b00, r_now}) - $signed({1'b0, r_rem});
        end
        if (i_cmd.set_x) begin
            r_x <= r_sow + $signed({14'd0, r_rs});
        end
        if (i_cmd.bucket) begin
            r_bk <= wsvl_pkg::BKT_TBL[w_u[32:25]];
        end
        if (i_cmd.cmp) begin
            r_dst <= w_in0 || w_in1;
        end
        if (i_cmd.app_init) begin
            r_x <= w_t;
        end
        if (i_cmd.app_entry && !o_sts.brk) begin
            r_x   <= w_t;
            r_cur <= r_rv;
            r_k   <= r_k + 5'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_od <= {r_vt, r_val};
            r_ou <= i_cmd.out_rec;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'd0, r_od};
    assign o_m_tuser  = r_ou;

endmodule

`default_nettype wire

// File: hdl/weekly_schedule_value_lookup_top.sv
// top level of the weekly schedule value lookup
// depends on wsvl_pkg, wsvl_ctrl and wsvl_dp
//
// usage:
//   input stream: tuser = operation; write items store one schedule entry, time
//   items present the current utc time. every input transaction gives exactly
//   one output transaction carrying current value, valid-until and a flag set
//   when the time item started a new schedule walk.
//   config port: write register 0 (initial value) or 1 (entry count) while idle.
// sequencing:
//   one item at a time. an entry write or a time before valid-until goes
//   straight to the output register. a walk does the week-start arithmetic,
//   sets the week start, then for each entry in use a memory read, add, year
//   bucket lookup, summer time compare and step; it stops at the first entry
//   that starts after the time, else it ends with the offset lookup at the
//   week end (an empty table also looks up the offset at the week start).
// reset: value and valid-until clear to zero so the first time item walks;
//   the entry memory holds nothing until written.
// stalls: the result waits in the output register while tready is low; the
//   next item is accepted meanwhile and its result waits for the register.
`default_nettype none

module weekly_schedule_value_lookup_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [31:0] time_utc, [35:32] entry_index, [55:36] entry_start, [87:56] entry_value
    input  wire logic [87:0] i_s_tdata,
    // [0] operation
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] current_value, [64:32] valid_until, [71:65] zero
    output logic [71:0]      o_m_tdata,
    // [0] recomputed
    output logic             o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    wsvl_pkg::t_cmd w_cmd;
    wsvl_pkg::t_sts w_sts;

    wsvl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wsvl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_time     (i_s_tdata[31:0]),
        .i_idx      (i_s_tdata[35:32]),
        .i_start    (i_s_tdata[55:36]),
        .i_value    (i_s_tdata[87:56]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/wsvl_checker.sv
// port-level checker of the schedule lookup, bound to the top level
// depends on weekly_schedule_value_lookup_top_defines.svh
`default_nettype none
`include "weekly_schedule_value_lookup_top_defines.svh"

module wsvl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [71:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    // a stalled result holds
    `WSVL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // one item in flight: ready drops right after an accepted transaction
    `WSVL_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // a walk always moves valid-until past the epoch
    `WSVL_ASSERT_NOW(a_rec_vt, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[64:32] != 33'd0)

endmodule

bind weekly_schedule_value_lookup_top wsvl_checker u_wsvl_checker (.*);

`default_nettype wire

// File: sim/weekly_schedule_value_lookup_top_test.sv
// self-checking testbench of the weekly schedule value lookup top level
// depends on wsvl_pkg and weekly_schedule_value_lookup_top; predicts each output in a class
`default_nettype none

module weekly_schedule_value_lookup_top_test;

    typedef struct {
        logic [31:0] value;
        logic [32:0] valid_to;
        logic        walked;
    } t_sched_out;

    class schedule_scoreboard;
        logic [19:0] starts [16];
        logic [31:0] values [16];
        logic [31:0] sched_value;
        logic [32:0] valid_to;
        logic [31:0] init_value;
        logic [4:0]  n_entries;
        t_sched_out  awaited [$];
        int          errors;

        function new();
            sched_value = '0;
            valid_to = '0;
            init_value = '0;
            n_entries = '0;
            errors = 0;
            foreach (starts[i]) begin
                starts[i] = '0;
                values[i] = '0;
            end
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
            return q;
        endfunction

        function longint day_number(longint y_in, longint m, longint d);
            longint y, era, yoe, doy;
            y = (m <= 2) ? y_in - 1 : y_in;
            era = fdiv(y, 400);
            yoe = y - era * 400;
            doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
            return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
        endfunction

        function longint civil_year(longint dn);
            longint z, era, doe, yoe, doy, mp;
            z = dn + 719468;
            era = fdiv(z, 146097);
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            return yoe + era * 400 + ((mp >= 10) ? 1 : 0);
        endfunction

        function longint monday_index(longint dn);
            return (dn + 3) - fdiv(dn + 3, 7) * 7;
        endfunction

        function longint final_sunday(longint y, longint m);
            longint last;
            last = day_number(y, m, 31);
            return last - ((monday_index(last) + 1) % 7);
        endfunction

        // local cet/cest time to utc shift
        function longint zone_shift(longint t);
            longint y, summer_on, summer_off;
            y = civil_year(fdiv(t, 86400));
            summer_on = final_sunday(y, 3) * 86400 + 7200;
            summer_off = final_sunday(y, 10) * 86400 + 10800;
            return (t < summer_on || t >= summer_off) ? -3600 : -7200;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            if (idx == wsvl_pkg::CFG_INIT) init_value = data;
            else if (idx == wsvl_pkg::CFG_COUNT) n_entries = data[4:0];
        endfunction

        function void note_item(logic op, logic [31:0] tm, logic [3:0] idx,
                                logic [19:0] st, logic [31:0] val);
            t_sched_out r;
            longint now, dn, sow, t, s;
            int n, k;
            r.walked = 1'b0;
            if (op == wsvl_pkg::OP_WRITE) begin
                starts[idx] = st;
                values[idx] = val;
            end else begin
                now = longint'(tm);
                if (now >= longint'(valid_to)) begin
                    dn = fdiv(now, 86400);
                    sow = (dn - monday_index(dn)) * 86400;
                    n = (n_entries > 16) ? 16 : n_entries;
                    t = sow + zone_shift(sow);
                    for (k = 0; k < n; k++) begin
                        s = sow + longint'(starts[k]);
                        t = s + zone_shift(s);
                        if (t > now) break;
                    end
                    sched_value = (k > 0) ? values[k-1] : init_value;
                    if (k == n) t = sow + 604800 + zone_shift(t);
                    valid_to = t[32:0];
                    r.walked = 1'b1;
                end
            end
            r.value = sched_value;
            r.valid_to = valid_to;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [71:0] data, logic user);
            t_sched_out e;
            if (awaited.size() == 0) begin
                $error("output transaction with no expected result");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (data[31:0] !== e.value) begin
                $error("current_value expected %h actual %h", e.value, data[31:0]);
                errors++;
            end
            if (data[64:32] !== e.valid_to) begin
                $error("valid_until expected %h actual %h", e.valid_to, data[64:32]);
                errors++;
            end
            if (user !== e.walked) begin
                $error("recomputed expected %b actual %b", e.walked, user);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    schedule_scoreboard sched_sb;
    bit          no_idle;
    int          sink_hold;
    int          items_sent;
    logic [31:0] clock_now;

    weekly_schedule_value_lookup_top u_top (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #40_000_000;
        $display("FAIL weekly_schedule_value_lookup_top");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side back-pressure
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (no_idle || $urandom_range(0, 3) != 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= 1'b0;
            sink_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sched_sb.check_result(o_m_tdata, o_m_tuser);
    end

    task automatic send_item(logic op, logic [31:0] tm, logic [3:0] idx,
                             logic [19:0] st, logic [31:0] val);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {val, st, idx, tm};
        do @(posedge i_clk); while (!o_s_tready);
        sched_sb.note_item(op, tm, idx, st, val);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_time(logic [31:0] tm);
        send_item(wsvl_pkg::OP_TIME, tm, 4'($urandom), 20'($urandom), $urandom);
    endtask

    task automatic send_entry(logic [3:0] idx, logic [19:0] st, logic [31:0] val);
        send_item(wsvl_pkg::OP_WRITE, $urandom, idx, st, val);
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sched_sb.awaited.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sched_sb.set_register(idx, data);
    endtask

    // time stream that mostly moves forward, often landing on the recompute boundary
    task automatic random_time();
        int r;
        longint nxt;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            send_time($urandom);
            return;
        end
        if (r < 45) nxt = longint'(clock_now) + $urandom_range(0, 3600);
        else if (r < 75) nxt = longint'(sched_sb.valid_to) + $urandom_range(0, 4) - 2;
        else if (r < 93) nxt = longint'(clock_now) + $urandom_range(0, 7 * 86400);
        else nxt = longint'(clock_now) + $urandom_range(0, 1 << 25);
        if (nxt > 64'hF000_0000 || nxt < longint'(clock_now)) nxt = clock_now;
        clock_now = nxt[31:0];
        send_time(clock_now);
    endtask

    initial begin
        logic [4:0] counts [6];
        logic [19:0] st;
        int n;
        sched_sb = new();
        no_idle = 1'b0;
        sink_hold = 0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= wsvl_pkg::OP_WRITE;
        i_m_tready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= wsvl_pkg::CFG_INIT;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table right after reset, then fill every slot
        send_time(32'd0);
        send_time(32'd100);
        for (int i = 0; i < 16; i++) begin
            st = (i == 15) ? 20'hFFFFF : 20'(i * 37800);
            send_entry(4'(i), st, (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
        end
        drain();
        write_reg(wsvl_pkg::CFG_INIT, 32'hFFFF_FFFF);
        write_reg(wsvl_pkg::CFG_COUNT, 32'd16);
        write_reg(2'd2, $urandom);
        write_reg(2'd3, $urandom);
        // around the march and october switch-overs of 2021
        send_time(32'd1616893199);
        send_time(32'd1616893200);
        send_time(32'd1635641999);
        send_time(32'd1635645600);
        clock_now = 32'd1635645600;

        counts = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd8};
        for (int ph = 0; items_sent < 1400; ph++) begin
            drain();
            no_idle = (ph % 5 == 3);
            write_reg(wsvl_pkg::CFG_COUNT, (ph < 6) ? 32'(counts[ph]) : $urandom_range(0, 31));
            write_reg(wsvl_pkg::CFG_INIT, (ph % 3 == 0) ? 32'd0
                                        : (ph % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
            if ($urandom_range(0, 3) == 0) write_reg(2'($urandom_range(2, 3)), $urandom);
            n = $urandom_range(60, 150);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    st = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, 604799));
                    send_entry(4'($urandom), st, $urandom);
                end else begin
                    random_time();
                end
            end
        end
        send_time(32'hFFFF_FFFF);
        drain();
        if (sched_sb.errors == 0) begin
            $display("PASS weekly_schedule_value_lookup_top");
        end else begin
            $display("FAIL weekly_schedule_value_lookup_top");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: weekly_schedule_value_lookup_top.f
+incdir+hdl
hdl/wsvl_pkg.sv
hdl/wsvl_ctrl.sv
hdl/wsvl_dp.sv
hdl/weekly_schedule_value_lookup_top.sv
hdl/wsvl_checker.sv
sim/weekly_schedule_value_lookup_top_test.sv
